// ----- rtl/fsmf_pkg.sv -----
// ----------------------------------------------------------------------------
// fsmf_pkg
// Shared types and constants for the first substring match finder.
// ----------------------------------------------------------------------------
package fsmf_pkg;

    localparam int BYTE_W     = 8;
    localparam int LEN_W      = 6;
    localparam int POS_W      = 16;
    localparam int PAT_WORDS  = 4;
    localparam int WORD_BYTES = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    localparam int              DEF_MAX_PATTERN = 32;
    localparam longint unsigned DEF_MAX_TEXT    = 65536;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN_LENGTH = 3'd0,
        CFG_PATTERN_WORD_0 = 3'd1,
        CFG_PATTERN_WORD_1 = 3'd2,
        CFG_PATTERN_WORD_2 = 3'd3,
        CFG_PATTERN_WORD_3 = 3'd4
    } t_cfg_reg;

    // broadcast from the top level to every cell of the row
    typedef struct packed {
        logic              step;
        logic              clear;
        logic [BYTE_W-1:0] text_byte;
    } t_cell_ctl;

endpackage

// ----- rtl/fsmf_cfg.sv -----
// ----------------------------------------------------------------------------
// fsmf_cfg
// Configuration registers: pattern length and the four pattern words.
// ----------------------------------------------------------------------------
module fsmf_cfg #(
    parameter int MAX_PATTERN = fsmf_pkg::DEF_MAX_PATTERN
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_cfg_we,
    input  logic [fsmf_pkg::CFG_IDX_W-1:0]              i_cfg_index,
    input  logic [fsmf_pkg::CFG_DATA_W-1:0]             i_cfg_data,
    output logic [fsmf_pkg::PAT_WORDS-1:0][fsmf_pkg::CFG_DATA_W-1:0] o_pat_words,
    output logic [fsmf_pkg::LEN_W-1:0]                  o_eff_len
);

    logic [fsmf_pkg::LEN_W-1:0]                              r_len;
    logic [fsmf_pkg::PAT_WORDS-1:0][fsmf_pkg::CFG_DATA_W-1:0] r_words;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len   <= '0;
            r_words <= '0;
        end else if (i_cfg_we) begin
            unique case (fsmf_pkg::t_cfg_reg'(i_cfg_index))
                fsmf_pkg::CFG_PATTERN_LENGTH: r_len <= i_cfg_data[fsmf_pkg::LEN_W-1:0];
                fsmf_pkg::CFG_PATTERN_WORD_0: r_words[0] <= i_cfg_data;
                fsmf_pkg::CFG_PATTERN_WORD_1: r_words[1] <= i_cfg_data;
                fsmf_pkg::CFG_PATTERN_WORD_2: r_words[2] <= i_cfg_data;
                fsmf_pkg::CFG_PATTERN_WORD_3: r_words[3] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // lengths above the cell count clamp to the full row
    assign o_eff_len = (r_len > fsmf_pkg::LEN_W'(MAX_PATTERN))
                     ? fsmf_pkg::LEN_W'(MAX_PATTERN) : r_len;
    assign o_pat_words = r_words;

endmodule

// ----- rtl/fsmf_cell.sv -----
// ----------------------------------------------------------------------------
// fsmf_cell
// One prefix cell: holds the match bit of one pattern prefix and passes it on.
// ----------------------------------------------------------------------------
module fsmf_cell (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  fsmf_pkg::t_cell_ctl           i_ctl,
    input  logic [fsmf_pkg::BYTE_W-1:0]   i_pat_byte,
    input  logic                          i_enable,
    input  logic                          i_final,
    input  logic                          i_prev,
    output logic                          o_bit,
    output logic                          o_hit
);

    logic r_bit;
    logic n_bit;
    logic w_match;

    // prefix k+1 matches when prefix k matched one byte ago and this byte fits
    assign w_match = i_prev && i_enable && (i_ctl.text_byte == i_pat_byte);

    always_comb begin
        n_bit = r_bit;
        if (i_ctl.clear) begin
            n_bit = 1'b0;
        end else if (i_ctl.step) begin
            n_bit = w_match;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit <= 1'b0;
        end else begin
            r_bit <= n_bit;
        end
    end

    assign o_bit = r_bit;
    assign o_hit = i_ctl.step && i_final && w_match;

endmodule

// ----- rtl/first_substring_match_finder_top.sv -----
// ----------------------------------------------------------------------------
// first_substring_match_finder_top
// Streaming pattern search over a row of prefix cells; reports the first hit.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+------------------------------
//  in      | input     | i_in_valid / o_in_stall    | i_text_byte, i_last
//  out     | output    | o_out_valid / i_out_stall  | o_found, o_match_position,
//          |           |                            | o_too_long
//  cfg     | input     | i_cfg_we                   | i_cfg_index, i_cfg_data
//
//  One text byte per cycle while the input is not stalled; every cell compares it
//  with its pattern byte and takes its left neighbor's bit.
//  The result of a last beat sits in the output register the cycle after.
//  Input stalls only while a result is held and the output is stalled.
//  Synchronous active-low reset clears search state and configuration.
// ----------------------------------------------------------------------------
module first_substring_match_finder_top #(
    parameter int              MAX_PATTERN = fsmf_pkg::DEF_MAX_PATTERN,
    parameter longint unsigned MAX_TEXT    = fsmf_pkg::DEF_MAX_TEXT
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [fsmf_pkg::BYTE_W-1:0]       i_text_byte,
    input  logic                              i_last,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic                              o_found,
    output logic [fsmf_pkg::POS_W-1:0]        o_match_position,
    output logic                              o_too_long,
    input  logic                              i_cfg_we,
    input  logic [fsmf_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [fsmf_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int CNT_W = $clog2(MAX_TEXT + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_TEXT);

    logic [fsmf_pkg::PAT_WORDS-1:0][fsmf_pkg::CFG_DATA_W-1:0] w_pat_words;
    logic [fsmf_pkg::LEN_W-1:0] w_eff_len;

    logic [MAX_PATTERN-1:0] w_bits;
    logic [MAX_PATTERN-1:0] w_hits;
    fsmf_pkg::t_cell_ctl    w_ctl;

    logic [CNT_W-1:0]               r_count, n_count;
    logic                           r_found, n_found;
    logic [fsmf_pkg::POS_W-1:0]     r_start, n_start;
    logic                           r_ovf, n_ovf;
    logic                           r_out_valid, n_out_valid;
    logic                           r_out_found;
    logic [fsmf_pkg::POS_W-1:0]     r_out_pos;
    logic                           r_out_too_long;

    logic                               w_accept;
    logic                               w_sat;
    logic                               w_step;
    logic                               w_hit;
    logic [CNT_W+fsmf_pkg::POS_W-1:0]   w_cnt_ext;
    logic [fsmf_pkg::POS_W-1:0]         w_hit_start;

    fsmf_cfg #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_pat_words (w_pat_words),
        .o_eff_len   (w_eff_len)
    );

    assign o_in_stall = r_out_valid && i_out_stall;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_sat      = (r_count >= CNT_MAX);
    assign w_step     = w_accept && !w_sat && (w_eff_len != '0);

    assign w_ctl.step      = w_step;
    assign w_ctl.clear     = w_accept && i_last;
    assign w_ctl.text_byte = i_text_byte;

    for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
        logic w_prev;
        if (k == 0) begin : g_head
            assign w_prev = 1'b1;
        end else begin : g_link
            assign w_prev = w_bits[k-1];
        end

        fsmf_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (w_ctl),
            .i_pat_byte (w_pat_words[k / fsmf_pkg::WORD_BYTES]
                                    [(k % fsmf_pkg::WORD_BYTES) * fsmf_pkg::BYTE_W
                                     +: fsmf_pkg::BYTE_W]),
            .i_enable   (w_eff_len > fsmf_pkg::LEN_W'(k)),
            .i_final    (w_eff_len == fsmf_pkg::LEN_W'(k + 1)),
            .i_prev     (w_prev),
            .o_bit      (w_bits[k]),
            .o_hit      (w_hits[k])
        );
    end

    assign w_hit       = |w_hits;
    assign w_cnt_ext   = {{fsmf_pkg::POS_W{1'b0}}, r_count};
    // start of the occurrence that ends on this byte, kept to 16 bits
    assign w_hit_start = w_cnt_ext[fsmf_pkg::POS_W-1:0] + fsmf_pkg::POS_W'(1)
                       - fsmf_pkg::POS_W'(w_eff_len);

    always_comb begin
        n_count = r_count;
        n_found = r_found;
        n_start = r_start;
        n_ovf   = r_ovf;
        if (w_accept) begin
            if (w_sat) begin
                n_ovf = 1'b1;
            end else begin
                n_count = r_count + CNT_W'(1);
            end
            if (w_hit && !r_found) begin
                n_found = 1'b1;
                n_start = w_hit_start;
            end
        end
        n_out_valid = (w_accept && i_last) || (r_out_valid && i_out_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_found     <= 1'b0;
            r_start     <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (w_accept && i_last) begin
                r_count <= '0;
                r_found <= 1'b0;
                r_start <= '0;
                r_ovf   <= 1'b0;
            end else begin
                r_count <= n_count;
                r_found <= n_found;
                r_start <= n_start;
                r_ovf   <= n_ovf;
            end
        end
    end

    // result beat register
    always_ff @(posedge i_clk) begin
        if (w_accept && i_last) begin
            if (w_eff_len == '0) begin
                r_out_found <= 1'b1;
                r_out_pos   <= '0;
            end else begin
                r_out_found <= n_found;
                r_out_pos   <= n_found ? n_start : '0;
            end
            r_out_too_long <= n_ovf;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_found          = r_out_found;
    assign o_match_position = r_out_pos;
    assign o_too_long       = r_out_too_long;

    a_last_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_last) |=> o_out_valid)
        else $error("last beat did not produce a result");

    a_pos_zero_when_missing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_found) |-> (o_match_position == '0))
        else $error("position set without a match");

    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_MAX)
        else $error("byte count passed its limit");

    a_stall_only_when_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled with no result held");

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Streams texts into the first substring match finder under a series of
// pattern settings and checks every report against a bit-level search
// tracker: empty, clamped and full-width patterns, overlapping prefixes,
// and random texts with planted occurrences,
// with random gaps on the input and random stalls on the output, each switched off in some random phases.
// ----------------------------------------------------------------------------
module testbench;

    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int RANDOM_BYTES = 1000;
    localparam logic [fsmf_pkg::CFG_IDX_W-1:0] CFG_UNMAPPED = '1;

    typedef struct packed {
        logic [fsmf_pkg::BYTE_W-1:0] data;
        logic                        last;
    } t_text_beat;

    typedef struct packed {
        logic                       found;
        logic [fsmf_pkg::POS_W-1:0] pos;
        logic                       too_long;
    } t_search_report;

    logic                            i_clk         = 1'b0;
    logic                            i_rst_n       = 1'b0;
    logic                            i_in_valid    = 1'b0;
    logic                            o_in_stall;
    logic [fsmf_pkg::BYTE_W-1:0]     i_text_byte   = '0;
    logic                            i_last        = 1'b0;
    logic                            o_out_valid;
    logic                            i_out_stall   = 1'b0;
    logic                            o_found;
    logic [fsmf_pkg::POS_W-1:0]      o_match_position;
    logic                            o_too_long;
    logic                            i_cfg_we      = 1'b0;
    logic [fsmf_pkg::CFG_IDX_W-1:0]  i_cfg_index   = '0;
    logic [fsmf_pkg::CFG_DATA_W-1:0] i_cfg_data    = '0;

    first_substring_match_finder_top dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_text_byte      (i_text_byte),
        .i_last           (i_last),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_found          (o_found),
        .o_match_position (o_match_position),
        .o_too_long       (o_too_long),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // search tracker: configuration copy and per-text state
    logic [fsmf_pkg::LEN_W-1:0]           cfg_len = '0;
    logic [fsmf_pkg::CFG_DATA_W-1:0]      cfg_words [fsmf_pkg::PAT_WORDS] = '{default: '0};
    logic [fsmf_pkg::DEF_MAX_PATTERN-1:0] prefix_hits = '0;
    longint unsigned                      text_bytes_seen = 0;
    logic                                 hit_seen = 1'b0;
    logic [fsmf_pkg::POS_W-1:0]           hit_start = '0;
    logic                                 overran = 1'b0;

    t_text_beat     pending_beats [$];
    t_search_report reports_due [$];
    logic [fsmf_pkg::BYTE_W-1:0] text_buf [$];

    logic [fsmf_pkg::BYTE_W-1:0] pattern_bytes [fsmf_pkg::DEF_MAX_PATTERN];
    logic [fsmf_pkg::BYTE_W-1:0] alphabet [4];
    int unsigned alpha_n = 1;

    bit          idle_on = 1'b1;
    bit          stall_on = 1'b1;
    bit          beat_taken = 1'b0;
    bit          out_held = 1'b0;
    int unsigned gap_left = 0;
    int unsigned stall_left = 0;
    int unsigned cycle_count = 0;
    int unsigned failures = 0;
    int unsigned reports_checked = 0;
    int unsigned beats_sent = 0;
    int unsigned texts_sent = 0;
    int unsigned settings_count = 0;
    int unsigned random_beats = 0;
    t_text_beat     next_beat;
    t_search_report predicted;
    t_search_report want;

    function automatic bit scan_byte(input logic [fsmf_pkg::BYTE_W-1:0] b,
                                     input logic is_last,
                                     output t_search_report rpt);
        int unsigned eff;
        logic [fsmf_pkg::DEF_MAX_PATTERN-1:0] byte_hits;
        eff = (cfg_len > fsmf_pkg::DEF_MAX_PATTERN) ? fsmf_pkg::DEF_MAX_PATTERN : cfg_len;
        rpt = '0;
        if (text_bytes_seen >= fsmf_pkg::DEF_MAX_TEXT) begin
            overran = 1'b1;
        end else begin
            if (eff > 0) begin
                byte_hits = '0;
                for (int k = 0; k < eff; k++) begin
                    if (cfg_words[k / fsmf_pkg::WORD_BYTES]
                                 [(k % fsmf_pkg::WORD_BYTES) * fsmf_pkg::BYTE_W
                                  +: fsmf_pkg::BYTE_W] == b)
                        byte_hits[k] = 1'b1;
                end
                prefix_hits = ((prefix_hits << 1) | 1) & byte_hits;
                if (!hit_seen && prefix_hits[eff-1]) begin
                    hit_seen  = 1'b1;
                    hit_start = fsmf_pkg::POS_W'(text_bytes_seen + 1 - eff);
                end
            end
            text_bytes_seen++;
        end
        if (!is_last)
            return 1'b0;
        rpt.found    = (eff == 0) || hit_seen;
        rpt.pos      = (eff != 0 && hit_seen) ? hit_start : '0;
        rpt.too_long = overran;
        prefix_hits     = '0;
        text_bytes_seen = 0;
        hit_seen        = 1'b0;
        hit_start       = '0;
        overran         = 1'b0;
        return 1'b1;
    endfunction

    // mostly short idles, now and then a long one
    function automatic int unsigned idle_len();
        return ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    endfunction

    function automatic logic [fsmf_pkg::BYTE_W-1:0] pick_symbol();
        if ($urandom_range(0, 99) < 85)
            return alphabet[$urandom_range(0, alpha_n - 1)];
        return fsmf_pkg::BYTE_W'($urandom_range(0, 255));
    endfunction

    // input side: accept at the rising edge, present the next beat at the falling edge
    always @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            beat_taken = 1'b1;
            beats_sent++;
            if (scan_byte(i_text_byte, i_last, predicted))
                reports_due.push_back(predicted);
        end
    end

    always @(negedge i_clk) begin
        if (!i_in_valid || beat_taken) begin
            beat_taken = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
                i_in_valid <= 1'b0;
            end else if (pending_beats.size() > 0) begin
                next_beat = pending_beats.pop_front();
                i_in_valid  <= 1'b1;
                i_text_byte <= next_beat.data;
                i_last      <= next_beat.last;
                gap_left = (idle_on && $urandom_range(0, 99) < 35) ? idle_len() : 0;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // output side: stall in bursts
    always @(negedge i_clk) begin
        if (stall_left == 0) begin
            out_held   = stall_on && ($urandom_range(0, 99) < 30);
            stall_left = out_held ? idle_len() : $urandom_range(1, 6);
        end
        stall_left--;
        i_out_stall <= out_held;
    end

    always @(posedge i_clk) begin
        if (o_out_valid && !i_out_stall) begin
            if (reports_due.size() == 0) begin
                $error("unexpected report: found %0d position %0d too_long %0d",
                       o_found, o_match_position, o_too_long);
                failures++;
            end else begin
                want = reports_due.pop_front();
                reports_checked++;
                if (o_found !== want.found) begin
                    $error("found: expected %0d, got %0d", want.found, o_found);
                    failures++;
                end
                if (o_match_position !== want.pos) begin
                    $error("match_position: expected %0d, got %0d", want.pos, o_match_position);
                    failures++;
                end
                if (o_too_long !== want.too_long) begin
                    $error("too_long: expected %0d, got %0d", want.too_long, o_too_long);
                    failures++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $error("timed out after %0d cycles, %0d reports outstanding",
                   cycle_count, reports_due.size());
            $display("FAIL first_substring_match_finder_top");
            $finish;
        end
    end

    task automatic write_reg(input logic [fsmf_pkg::CFG_IDX_W-1:0] idx,
                             input logic [fsmf_pkg::CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        case (idx) inside
            fsmf_pkg::CFG_PATTERN_LENGTH: cfg_len = data[fsmf_pkg::LEN_W-1:0];
            fsmf_pkg::CFG_PATTERN_WORD_0, fsmf_pkg::CFG_PATTERN_WORD_1,
            fsmf_pkg::CFG_PATTERN_WORD_2, fsmf_pkg::CFG_PATTERN_WORD_3: begin
                cfg_words[idx - fsmf_pkg::CFG_PATTERN_WORD_0] = data;
            end
            default: ;
        endcase
    endtask

    // length register gets junk in its upper bits, bytes past the length are junk too
    task automatic load_pattern(input int unsigned len_value);
        logic [fsmf_pkg::CFG_DATA_W-1:0] data;
        data = {$urandom(), $urandom()};
        data[fsmf_pkg::LEN_W-1:0] = fsmf_pkg::LEN_W'(len_value);
        write_reg(fsmf_pkg::CFG_PATTERN_LENGTH, data);
        for (int w = 0; w < fsmf_pkg::PAT_WORDS; w++) begin
            for (int j = 0; j < fsmf_pkg::WORD_BYTES; j++)
                data[j * fsmf_pkg::BYTE_W +: fsmf_pkg::BYTE_W] =
                    pattern_bytes[w * fsmf_pkg::WORD_BYTES + j];
            write_reg(fsmf_pkg::CFG_IDX_W'(fsmf_pkg::CFG_PATTERN_WORD_0 + w), data);
        end
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        settings_count++;
    endtask

    task automatic push_fill(input logic [fsmf_pkg::BYTE_W-1:0] value, input int unsigned n);
        repeat (n) text_buf.push_back(value);
    endtask

    task automatic push_pattern(input int unsigned n);
        for (int k = 0; k < n; k++)
            text_buf.push_back(pattern_bytes[k]);
    endtask

    task automatic commit_text();
        for (int i = 0; i < text_buf.size(); i++)
            pending_beats.push_back('{data: text_buf[i], last: (i == text_buf.size() - 1)});
        text_buf.delete();
        texts_sent++;
    endtask

    task automatic wait_idle();
        while (pending_beats.size() != 0 || i_in_valid || reports_due.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic random_text(input int unsigned plant_len);
        int unsigned n;
        int unsigned at;
        case ($urandom_range(0, 19)) inside
            [0:13]:  n = $urandom_range(1, 20);
            [14:18]: n = $urandom_range(21, 60);
            default: n = $urandom_range(61, 200);
        endcase
        repeat (n) text_buf.push_back(pick_symbol());
        if (plant_len > 0 && n >= plant_len && $urandom_range(0, 99) < 60) begin
            at = $urandom_range(0, n - plant_len);
            for (int k = 0; k < plant_len; k++)
                text_buf[at + k] = pattern_bytes[k];
        end
        random_beats += n;
        commit_text();
    endtask

    initial begin
        int unsigned len_value;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // empty pattern straight out of reset
        text_buf = {8'h00};
        commit_text();
        text_buf = {8'hFF, 8'h5A};
        commit_text();
        wait_idle();

        // single byte pattern, plus a write to an unmapped index that must be ignored
        foreach (pattern_bytes[k]) pattern_bytes[k] = fsmf_pkg::BYTE_W'($urandom_range(0, 255));
        pattern_bytes[0] = 8'hFF;
        write_reg(CFG_UNMAPPED, '1);
        load_pattern(1);
        text_buf = {8'h00, 8'hFF};
        commit_text();
        text_buf = {8'h00, 8'h7F};
        commit_text();
        wait_idle();

        // overlapping prefixes where a partial match must fall back
        pattern_bytes[0:3] = '{8'hAA, 8'h55, 8'hAA, 8'h55};
        load_pattern(4);
        text_buf = {8'hAA, 8'h55, 8'hAA, 8'hAA, 8'h55, 8'hAA, 8'h55};
        commit_text();
        wait_idle();
        pattern_bytes[0:2] = '{8'h01, 8'h01, 8'h02};
        load_pattern(3);
        text_buf = {8'h01, 8'h01, 8'h01, 8'h02};
        commit_text();
        wait_idle();

        // full-width pattern, length field above the maximum gets clamped
        foreach (pattern_bytes[k])
            pattern_bytes[k] = (k == 0) ? 8'h00 : fsmf_pkg::BYTE_W'(k * 8 + 7);
        load_pattern(63);
        text_buf = {8'hC3, 8'h3C};
        push_pattern(fsmf_pkg::DEF_MAX_PATTERN);
        commit_text();
        wait_idle();
        load_pattern(40);
        push_pattern(fsmf_pkg::DEF_MAX_PATTERN);
        push_fill(8'h01, 3);
        push_pattern(fsmf_pkg::DEF_MAX_PATTERN);
        commit_text();
        wait_idle();
        foreach (pattern_bytes[k]) pattern_bytes[k] = 8'hFF;
        load_pattern(fsmf_pkg::DEF_MAX_PATTERN);
        push_fill(8'hFF, fsmf_pkg::DEF_MAX_PATTERN - 1);
        commit_text();
        push_fill(8'hFF, fsmf_pkg::DEF_MAX_PATTERN + 1);
        commit_text();
        wait_idle();

        // random phases: small alphabets so matches and partial matches are common
        while (random_beats < RANDOM_BYTES) begin
            idle_on  = $urandom_range(0, 3) != 0;
            stall_on = $urandom_range(0, 3) != 0;
            alpha_n  = $urandom_range(1, 4);
            foreach (alphabet[i]) alphabet[i] = fsmf_pkg::BYTE_W'($urandom_range(0, 255));
            case ($urandom_range(0, 19)) inside
                0:       len_value = 0;
                [1:10]:  len_value = $urandom_range(1, 4);
                [11:16]: len_value = $urandom_range(5, fsmf_pkg::DEF_MAX_PATTERN);
                default: len_value = $urandom_range(fsmf_pkg::DEF_MAX_PATTERN + 1,
                                                    (1 << fsmf_pkg::LEN_W) - 1);
            endcase
            foreach (pattern_bytes[k]) pattern_bytes[k] = pick_symbol();
            load_pattern(len_value);
            repeat ($urandom_range(4, 12))
                random_text((len_value > fsmf_pkg::DEF_MAX_PATTERN)
                            ? fsmf_pkg::DEF_MAX_PATTERN : len_value);
            wait_idle();
        end

        repeat (10) @(posedge i_clk);
        $display("searched %0d texts (%0d bytes) under %0d pattern settings, %0d reports checked",
                 texts_sent, beats_sent, settings_count, reports_checked);
        $display("pattern lengths from empty to clamped, with gaps and output stalls");
        if (failures == 0) begin
            $display("PASS first_substring_match_finder_top");
        end else begin
            $display("FAIL first_substring_match_finder_top");
        end
        $finish;
    end

endmodule
